[rtl/sidac_pkg.sv]
package sidac_pkg;

  localparam int unsigned CHAR_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // Operation of the shared BCD shift unit
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_LOAD = 2'd1,
    OP_DAB  = 2'd2,
    OP_NIB  = 2'd3
  } bcd_op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CONV  = 3'd1,
    ST_SIGN  = 3'd2,
    ST_SKIP  = 3'd3,
    ST_DIGIT = 3'd4
  } seq_state_e;

endpackage

[rtl/sidac_bcd.sv]
module sidac_bcd import sidac_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned NDIG        = 19
) (
  input  logic                   clk_i,
  input  bcd_op_e                op_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  output logic [3:0]             top_digit_o
);

  localparam int unsigned BCD_W = 4 * NDIG;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    case (op_i)
      OP_LOAD: begin
        bin_d = mag_i;
        bcd_d = '0;
      end
      OP_DAB: begin
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
      end
      OP_NIB: begin
        bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
      end
      default: begin
        bin_d = bin_q;
        bcd_d = bcd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BCD_W-1 -: 4];

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// Signed integer to decimal ASCII text.
//
// Command port: an item (value_i) is taken at a rising edge where start_i is
// high and busy_o is low. Only the low VALUE_WIDTH bits of value_i are used,
// read as two's complement. busy_o stays high until the last character of the
// item has been shown.
//
// Result port: one ASCII character at a time marked by valid_o, most
// significant first: a minus sign for negative values, then the digits with
// no leading zeros (zero gives a single '0'). last_o flags the final one.
// Each character is present for exactly one cycle; the receiver cannot stall.
//
// Sequence: VALUE_WIDTH shift-and-add-three steps in one shared BCD unit, a
// step for a minus sign, one per dropped leading zero, one to find the leading
// digit and one per digit shown; zeros dropped plus digits shown is NDIG (19
// at the default width).
//
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// any item in progress; no character is emitted for it.
module signed_int_to_decimal_ascii_unit import sidac_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       value_i,
  output logic              busy_o,
  output logic              valid_o,
  output logic [CHAR_W-1:0] character_o,
  output logic              last_o
);

  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int unsigned NDIG  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DIG_W = $clog2(NDIG);

  seq_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIG_W-1:0] dig_q, dig_d;
  logic             neg_q, neg_d;

  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   accept;
  bcd_op_e                op;
  logic [3:0]             top_digit;

  assign val    = value_i[VALUE_WIDTH-1:0];
  // Negate in VALUE_WIDTH bits; the most negative value maps onto itself,
  // which read unsigned is the right magnitude
  assign mag    = val[VALUE_WIDTH-1] ? (~val + VALUE_WIDTH'(1)) : val;
  assign accept = start_i && (state_q == ST_IDLE);

  sidac_bcd #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_bcd (
    .clk_i       (clk_i),
    .op_i        (op),
    .mag_i       (mag),
    .top_digit_o (top_digit)
  );

  // Next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CONV;
          cnt_d   = CNT_W'(VALUE_WIDTH);
          neg_d   = val[VALUE_WIDTH-1];
        end
      end
      ST_CONV: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = neg_q ? ST_SIGN : ST_SKIP;
          dig_d   = DIG_W'(NDIG - 1);
        end
      end
      ST_SIGN: begin
        state_d = ST_SKIP;
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the units digit
        if ((top_digit == 4'd0) && (dig_q != '0)) begin
          dig_d = dig_q - DIG_W'(1);
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        dig_d = dig_q - DIG_W'(1);
        if (dig_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and shared unit control
  always_comb begin
    op          = OP_HOLD;
    busy_o      = 1'b1;
    valid_o     = 1'b0;
    character_o = CHAR_ZERO;
    last_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (accept) begin
          op = OP_LOAD;
        end
      end
      ST_CONV: begin
        op = OP_DAB;
      end
      ST_SIGN: begin
        valid_o     = 1'b1;
        character_o = CHAR_MINUS;
      end
      ST_SKIP: begin
        if ((top_digit == 4'd0) && (dig_q != '0)) begin
          op = OP_NIB;
        end
      end
      ST_DIGIT: begin
        op          = OP_NIB;
        valid_o     = 1'b1;
        character_o = CHAR_ZERO + {2'b00, top_digit};
        last_o      = (dig_q == '0);
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dig_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
      neg_q   <= neg_d;
    end
  end

endmodule

[tb/tb_signed_int_to_decimal_ascii_unit.sv]
module tb_signed_int_to_decimal_ascii_unit;
  import sidac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH   = 64;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned CALM_ITEMS    = 100;  // final stretch sent with no gaps
  localparam int unsigned TAIL_CYCLES   = 120;  // a bit more than one full conversion
  localparam int unsigned STALL_LIMIT   = 2000; // cycles with no item or character moving
  localparam int unsigned MAX_PRINTED   = 20;
  localparam logic [63:0] DECIMAL_RADIX = 64'd10;

  // Corner values: zero, one-digit and two-digit edges, powers of ten, both
  // extremes of the signed range, the most negative value and alternating bits.
  localparam logic [63:0] EDGE_VALUES [18] = '{
    64'd0,
    64'd1,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'd9,
    64'hFFFF_FFFF_FFFF_FFF7,
    64'd10,
    64'hFFFF_FFFF_FFFF_FFF6,
    64'd99,
    64'd100,
    64'd999999999999999999,
    64'd1000000000000000000,
    64'hF21F_494C_589C_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'd1234567890
  };

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first, and grades
  // each character the block shows against them.
  class decimal_text_scoreboard;
    text_char_t  owed_chars[$];
    int unsigned error_count;
    int unsigned value_width;

    function new(int unsigned width);
      value_width = width;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return owed_chars.size();
    endfunction

    // Convert one accepted value into the text it should produce.
    function void note_value(logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] bits;
      logic [63:0] magnitude;
      logic        is_negative;
      logic [3:0]  digits[$];
      text_char_t  entry;

      mask        = {64{1'b1}} >> (64 - value_width);
      bits        = value & mask;
      is_negative = bits[value_width-1];
      magnitude   = is_negative ? ((~bits + 64'd1) & mask) : bits;

      // Peel digits least significant first; zero still yields one digit.
      do begin
        digits.push_front(4'(magnitude % DECIMAL_RADIX));
        magnitude = magnitude / DECIMAL_RADIX;
      end while (magnitude != 64'd0);

      if (is_negative) begin
        entry.character = CHAR_MINUS;
        entry.last      = 1'b0;
        owed_chars.push_back(entry);
      end
      foreach (digits[i]) begin
        entry.character = CHAR_ZERO + CHAR_W'(digits[i]);
        entry.last      = (i == digits.size() - 1);
        owed_chars.push_back(entry);
      end
    endfunction

    task report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_PRINTED)
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Compare one shown character with the oldest one owed.
    task check_char(logic [CHAR_W-1:0] character, logic last);
      text_char_t owed;
      if (owed_chars.size() == 0) begin
        report_mismatch($sformatf("character %0d last %0b shown with nothing owed",
                                  character, last));
      end else begin
        owed = owed_chars.pop_front();
        if (character !== owed.character)
          report_mismatch($sformatf("character %0d, owed %0d", character, owed.character));
        if (last !== owed.last)
          report_mismatch($sformatf("last %0b, owed %0b (character %0d)",
                                    last, owed.last, owed.character));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic [63:0]       value_i;
  logic              busy_o;
  logic              valid_o;
  logic [CHAR_W-1:0] character_o;
  logic              last_o;

  decimal_text_scoreboard scoreboard = new(VALUE_WIDTH);
  int unsigned            stall_cycles;

  signed_int_to_decimal_ascii_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .valid_o    (valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Monitor: sample at the rising edge, which sees the values of the cycle
  // just ended. Grade a shown character before noting a new item, since any
  // character in that cycle belongs to an item taken earlier.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o)
        scoreboard.check_char(character_o, last_o);
      if (start_i && !busy_o)
        scoreboard.note_value(value_i);
    end
  end

  // Watchdog: end the run if neither side moves anything for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one value and hold it until the block takes it.
  task automatic send_value(logic [63:0] value);
    start_i <= 1'b1;
    value_i <= value;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  // Drop start for a few cycles; keep the value bus noisy so stray bits
  // while start is low are seen to be ignored.
  task automatic idle_sender(int unsigned cycles);
    start_i <= 1'b0;
    value_i <= {$urandom, $urandom};
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 2) == 0)
      idle_sender($urandom_range(1, 15));
  endtask

  // Hold off until every owed character has been shown. Wait for a clock edge
  // first so an item taken at the current edge is already noted.
  task automatic drain_pause();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.pending() != 0)
      @(posedge clk_i);
  endtask

  // Mostly short magnitudes of either sign, some values next to a power of
  // ten, and some fully random words.
  function automatic logic [63:0] random_value();
    logic [63:0] raw;
    logic [63:0] power;
    int unsigned pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      raw = raw >> $urandom_range(0, 63);
    end else if (pick < 8) begin
      power = 64'd1;
      repeat ($urandom_range(0, 18)) power = power * DECIMAL_RADIX;
      raw = power + 64'($urandom_range(0, 2)) - 64'd1;
    end else begin
      return raw;
    end
    if ($urandom_range(0, 1) == 1)
      raw = -raw;
    return raw;
  endfunction

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners first.
    foreach (EDGE_VALUES[i]) begin
      send_value(EDGE_VALUES[i]);
      maybe_idle();
    end
    drain_pause();

    // Random traffic; pause once midway until the text stream drains, and
    // send the final stretch back to back.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2)
        drain_pause();
      send_value(random_value());
      if (n < RANDOM_ITEMS - CALM_ITEMS)
        maybe_idle();
    end

    drain_pause();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (scoreboard.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
